>>> hdl/wsd_pkg.sv
// WebSocket deframer package: result kinds, error causes and the command
// item passed from the header parser to the output stage.
// No dependencies.
`default_nettype none

package wsd_pkg;

   // Result kinds as seen on the response side
   typedef enum logic [2:0] {
      K_MSG        = 3'd0,
      K_PING       = 3'd1,
      K_MSG_END    = 3'd2,
      K_PING_EMPTY = 3'd3,
      K_CLOSE      = 3'd4,
      K_ERROR      = 3'd5
   } kind_type;

   // Error causes
   localparam logic [2:0] CAUSE_RSV        = 3'd0;
   localparam logic [2:0] CAUSE_CTL_LONG   = 3'd1;
   localparam logic [2:0] CAUSE_CTL_FRAG   = 3'd2;
   localparam logic [2:0] CAUSE_MSG_LONG   = 3'd3;
   localparam logic [2:0] CAUSE_ORPHAN     = 3'd4;
   localparam logic [2:0] CAUSE_EMPTY_FRAG = 3'd5;
   localparam logic [2:0] CAUSE_BAD_DATA   = 3'd6;
   localparam logic [2:0] CAUSE_BAD_CTL    = 3'd7;

   // Opcodes of interest
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // Configuration register indexes
   localparam logic CSR_MAX_CTL = 1'b0;
   localparam logic CSR_MAX_MSG = 1'b1;

   localparam logic [6:0] MAX_CTL_RESET = 7'd125;
   localparam logic [6:0] MAX_MSG_RESET = 7'd125;

   // Default depth of the queue between parser and output stage
   localparam int QUEUE_DEPTH = 4;

   // One command: result kind, raw byte, the key byte it is unmasked with, last flag and cause
   typedef struct packed {
      kind_type   kind;
      logic [7:0] raw;
      logic [7:0] key;
      logic       last;
      logic [2:0] cause;
   } cmd_type;

   // Parser to queue
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_wr_type;

   // Queue to output stage
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_rd_type;

endpackage

`default_nettype wire

>>> hdl/wsd_front.sv
// Header parser: takes stream bytes, tracks frame state, checks the header
// and issues commands into the queue. Holds the configuration registers.
// Depends on wsd_pkg.
`default_nettype none

module wsd_front
   import wsd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic       full,
   input  wire logic [7:0] rx_byte,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_wdata,
   output q_wr_type        q_wr
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_KEY,
      PH_DATA,
      PH_DEAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [6:0]  length_ff, length_in;
   logic [6:0]  index_ff, index_in;
   logic [31:0] key_ff, key_in;
   logic [6:0]  count_ff, count_in;
   logic [6:0]  max_ctl_ff, max_ctl_in;
   logic [6:0]  max_msg_ff, max_msg_in;

   logic        accept;
   logic [7:0]  index_inc;
   logic [7:0]  msg_total;
   logic [7:0]  key_byte;
   logic        is_ctl;
   logic        data_last;

   assign accept    = push && !full;
   assign is_ctl    = opcode_ff[3];
   assign index_inc = {1'b0, index_ff} + 8'd1;
   assign msg_total = {1'b0, rx_byte[6:0]} + {1'b0, count_ff};
   assign data_last = index_inc >= {1'b0, length_ff};

   // key byte for this payload position, first received key byte first
   always_comb begin
      unique case (index_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // configuration writes
   always_comb begin
      max_ctl_in = max_ctl_ff;
      max_msg_in = max_msg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_CTL: max_ctl_in = csr_wdata;
            default:     max_msg_in = csr_wdata;
         endcase
      end
   end

   // parse step
   always_comb begin
      logic       hdr_done;
      logic       ctl_done;
      logic       fail;
      logic [2:0] cause;

      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      length_in = length_ff;
      index_in  = index_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      q_wr      = '0;
      hdr_done  = 1'b0;
      ctl_done  = 1'b0;
      fail      = 1'b0;
      cause     = CAUSE_RSV;

      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               if (rx_byte[6:4] != 3'd0) begin
                  fail  = 1'b1;
                  cause = CAUSE_RSV;
               end else begin
                  fin_in    = rx_byte[7];
                  opcode_in = rx_byte[3:0];
                  phase_in  = PH_HDR1;
               end
            end
            PH_HDR1: begin
               masked_in = rx_byte[7];
               length_in = rx_byte[6:0];
               priority if (is_ctl && rx_byte[6:0] > max_ctl_ff) begin
                  fail  = 1'b1;
                  cause = CAUSE_CTL_LONG;
               end else if (is_ctl && !fin_ff) begin
                  fail  = 1'b1;
                  cause = CAUSE_CTL_FRAG;
               end else if (!is_ctl && opcode_ff != OP_CONT && opcode_ff != OP_BINARY) begin
                  fail  = 1'b1;
                  cause = CAUSE_BAD_DATA;
               end else if (!is_ctl && msg_total > {1'b0, max_msg_ff}) begin
                  fail  = 1'b1;
                  cause = CAUSE_MSG_LONG;
               end else if (opcode_ff == OP_CONT && count_ff == 7'd0) begin
                  fail  = 1'b1;
                  cause = CAUSE_ORPHAN;
               end else if (!is_ctl && rx_byte[6:0] == 7'd0 && !fin_ff) begin
                  fail  = 1'b1;
                  cause = CAUSE_EMPTY_FRAG;
               end else if (rx_byte[7]) begin
                  index_in = 7'd0;
                  key_in   = '0;
                  phase_in = PH_KEY;
               end else begin
                  hdr_done = 1'b1;
               end
            end
            PH_KEY: begin
               key_in   = {key_ff[23:0], rx_byte};
               index_in = index_inc[6:0];
               hdr_done = index_inc >= 8'd4;
            end
            PH_DATA: begin
               index_in = index_inc[6:0];
               if (data_last) begin
                  phase_in = PH_HDR0;
               end
               if (!is_ctl) begin
                  count_in = (data_last && fin_ff) ? 7'd0 : index_inc[6:0] + count_ff
                             - index_ff;
                  q_wr.push      = 1'b1;
                  q_wr.cmd.kind  = K_MSG;
                  q_wr.cmd.raw   = rx_byte;
                  q_wr.cmd.key   = masked_ff ? key_byte : 8'd0;
                  q_wr.cmd.last  = data_last && fin_ff;
               end else if (opcode_ff == OP_PING) begin
                  q_wr.push      = 1'b1;
                  q_wr.cmd.kind  = K_PING;
                  q_wr.cmd.raw   = rx_byte;
                  q_wr.cmd.key   = masked_ff ? key_byte : 8'd0;
                  q_wr.cmd.last  = data_last;
               end else begin
                  ctl_done = data_last;
               end
            end
            default: begin
            end
         endcase
      end

      // header and key complete
      if (hdr_done) begin
         index_in = 7'd0;
         if (length_in != 7'd0) begin
            phase_in = PH_DATA;
         end else begin
            phase_in = PH_HDR0;
            if (!opcode_ff[3]) begin
               count_in      = 7'd0;
               q_wr.push     = 1'b1;
               q_wr.cmd.kind = K_MSG_END;
            end else if (opcode_ff == OP_PING) begin
               q_wr.push     = 1'b1;
               q_wr.cmd.kind = K_PING_EMPTY;
            end else begin
               ctl_done = 1'b1;
            end
         end
      end

      // whole control frame consumed
      if (ctl_done) begin
         phase_in = PH_HDR0;
         if (opcode_ff == OP_CLOSE) begin
            phase_in      = PH_DEAD;
            q_wr.push     = 1'b1;
            q_wr.cmd.kind = K_CLOSE;
         end else if (opcode_ff != OP_PING && opcode_ff != OP_PONG) begin
            fail  = 1'b1;
            cause = CAUSE_BAD_CTL;
         end
      end

      // protocol error: report once and go silent
      if (fail) begin
         phase_in       = PH_DEAD;
         q_wr.push      = 1'b1;
         q_wr.cmd.kind  = K_ERROR;
         q_wr.cmd.cause = cause;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         fin_ff     <= 1'b0;
         opcode_ff  <= 4'd0;
         masked_ff  <= 1'b0;
         length_ff  <= 7'd0;
         index_ff   <= 7'd0;
         key_ff     <= '0;
         count_ff   <= 7'd0;
         max_ctl_ff <= MAX_CTL_RESET;
         max_msg_ff <= MAX_MSG_RESET;
      end else begin
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         opcode_ff  <= opcode_in;
         masked_ff  <= masked_in;
         length_ff  <= length_in;
         index_ff   <= index_in;
         key_ff     <= key_in;
         count_ff   <= count_in;
         max_ctl_ff <= max_ctl_in;
         max_msg_ff <= max_msg_in;
      end
   end

   // silent for good after close or error
   a_dead_stays: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DEAD |=> phase_ff == PH_DEAD)
      else $error("parser left the dead phase");

   a_final_kills: assert property (@(posedge clock) disable iff (reset)
      q_wr.push && (q_wr.cmd.kind == K_CLOSE || q_wr.cmd.kind == K_ERROR)
      |=> phase_ff == PH_DEAD)
      else $error("close or error not followed by dead phase");

   a_key_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_KEY |-> index_ff < 7'd4)
      else $error("key byte counter out of range");

endmodule

`default_nettype wire

>>> hdl/wsd_queue.sv
// Command queue between header parser and output stage.
// Circular buffer in flip-flops. Depends on wsd_pkg.
`default_nettype none

module wsd_queue
   import wsd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire q_wr_type q_wr,
   input  wire logic     pop,
   output logic          full,
   output q_rd_type      q_rd
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   cmd_type         store_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = count_ff == FullCnt;
   assign do_push    = q_wr.push && !full;
   assign do_pop     = pop && count_ff != '0;
   assign q_rd.valid = count_ff != '0;
   assign q_rd.cmd   = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= q_wr.cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue fill count above depth");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      q_wr.push |-> !full)
      else $error("command pushed into a full queue");

endmodule

`default_nettype wire

>>> hdl/wsd_back.sv
// Output stage: takes commands from the queue, unmasks payload bytes and
// holds the oldest result until popped. Depends on wsd_pkg.
`default_nettype none

module wsd_back
   import wsd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire q_rd_type q_rd,
   output logic          q_pop,
   input  wire logic     pop,
   output logic          empty,
   output logic [2:0]    rsp_kind,
   output logic [7:0]    rsp_payload_byte,
   output logic          rsp_is_last,
   output logic [2:0]    rsp_error_cause
);

   logic       valid_ff, valid_in;
   logic [2:0] kind_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic [2:0] cause_ff;
   logic       load;

   // refill when the slot is free or being taken this cycle
   assign load     = q_rd.valid && (!valid_ff || pop);
   assign q_pop    = load;
   assign valid_in = load || (valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload, unmasking on load
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= q_rd.cmd.kind;
         byte_ff  <= q_rd.cmd.raw ^ q_rd.cmd.key;
         last_ff  <= q_rd.cmd.last;
         cause_ff <= q_rd.cmd.cause;
      end
   end

   assign empty            = !valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_is_last      = last_ff;
   assign rsp_error_cause  = cause_ff;

   a_no_byte_on_status: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_kind != K_MSG && rsp_kind != K_PING
      |-> rsp_payload_byte == 8'd0 && !rsp_is_last)
      else $error("status result carries a payload byte");

endmodule

`default_nettype wire

>>> hdl/websocket_frame_deframer_core.sv
// WebSocket frame deframer, top level: header parser, command queue and
// output stage. Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back.
//
//   Channel   Handshake        Payload
//   request   push / full      req_rx_byte
//   response  empty / pop      rsp_kind, rsp_payload_byte, rsp_is_last,
//                              rsp_error_cause
//   csr       csr_wr_en        csr_index, csr_wdata
//
// One byte is accepted per cycle while full is low; the parser state is updated in that cycle.
// A result is written into the queue when its byte is accepted and reaches the
// response side through the output register, which loads only when free or popped.
// full rises only when the output register and all DEPTH queue entries
// hold results that the consumer has not popped.
// Synchronous active-high reset: back to the first header byte, limits 125.
`default_nettype none

module websocket_frame_deframer_core
   import wsd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_rx_byte,
   output logic            empty,
   input  wire logic       pop,
   output logic [2:0]      rsp_kind,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_is_last,
   output logic [2:0]      rsp_error_cause,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_wdata
);

   q_wr_type q_wr;
   q_rd_type q_rd;
   logic     q_pop;

   wsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rx_byte   (req_rx_byte),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_wr      (q_wr)
   );

   wsd_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .q_wr  (q_wr),
      .pop   (q_pop),
      .full  (full),
      .q_rd  (q_rd)
   );

   wsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_rd             (q_rd),
      .q_pop            (q_pop),
      .pop              (pop),
      .empty            (empty),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_is_last      (rsp_is_last),
      .rsp_error_cause  (rsp_error_cause)
   );

endmodule

`default_nettype wire

>>> sim/websocket_frame_deframer_core_tb.sv
// Self-checking testbench for websocket_frame_deframer_core: streams framed
// bytes, predicts each deframed result and checks everything the block pops.
// Depends on wsd_pkg and the websocket_frame_deframer_core RTL only.
`default_nettype none

module websocket_frame_deframer_core_tb
   import wsd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_SPAN   = 400;

   // Parser phases of the predictor
   typedef enum logic [2:0] {
      PS_HEAD0,
      PS_HEAD1,
      PS_KEY,
      PS_PAYLOAD,
      PS_DEAD
   } parse_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
      logic [2:0] cause;
   } deframed_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_rx_byte = 8'h00;
   logic       empty;
   logic       pop = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic       rsp_is_last;
   logic [2:0] rsp_error_cause;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = CSR_MAX_CTL;
   logic [6:0] csr_wdata = 7'd0;

   // Byte stream waiting to be offered, and results still owed by the block
   logic [7:0]   rx_stream[$];
   deframed_type awaited[$];

   // Predictor state and its copy of the limits
   parse_state_type ps;
   logic            fin_q;
   logic [3:0]      opcode_q;
   logic            masked_q;
   logic [6:0]      length_q;
   logic [6:0]      index_q;
   logic [6:0]      msg_bytes_q;
   logic [31:0]     key_q;
   logic [6:0]      ctl_limit;
   logic [6:0]      msg_limit;

   // Limits as the stimulus generator believes them to be
   int gen_ctl = 125;
   int gen_msg = 125;

   int send_idle_pct = 17;
   int recv_idle_pct = 73;
   bit hold_wanted = 1'b0;
   bit hold_done;
   int hold_cycles;

   int    staged_bytes = 0;
   int    bytes_taken = 0;
   int    results_checked = 0;
   int    stall_cycles = 0;
   int    errors = 0;
   int    cycle_count = 0;
   string closing_note = "no terminating frame";

   websocket_frame_deframer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_rx_byte      (req_rx_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_is_last      (rsp_is_last),
      .rsp_error_cause  (rsp_error_cause),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void report(kind_type k, logic [7:0] d, logic l, logic [2:0] c);
      awaited.push_back('{kind: k, data: d, last: l, cause: c});
   endfunction

   function automatic void protocol_error(logic [2:0] c);
      ps = PS_DEAD;
      report(K_ERROR, 8'h00, 1'b0, c);
   endfunction

   // Whole control frame consumed: close ends the stream, unknown opcodes fail
   function automatic void control_complete();
      ps = PS_HEAD0;
      if (opcode_q == OP_CLOSE) begin
         ps = PS_DEAD;
         report(K_CLOSE, 8'h00, 1'b0, 3'd0);
      end else if (opcode_q != OP_PING && opcode_q != OP_PONG) begin
         protocol_error(CAUSE_BAD_CTL);
      end
   endfunction

   // Header and any masking key are in
   function automatic void header_complete();
      index_q = 7'd0;
      if (length_q != 7'd0) begin
         ps = PS_PAYLOAD;
      end else begin
         ps = PS_HEAD0;
         if (!opcode_q[3]) begin
            msg_bytes_q = 7'd0;
            report(K_MSG_END, 8'h00, 1'b0, 3'd0);
         end else if (opcode_q == OP_PING) begin
            report(K_PING_EMPTY, 8'h00, 1'b0, 3'd0);
         end else begin
            control_complete();
         end
      end
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      logic [7:0] d;
      logic       at_end;
      case (ps)
         PS_HEAD0: begin
            if (b[6:4] != 3'b000) begin
               protocol_error(CAUSE_RSV);
            end else begin
               fin_q    = b[7];
               opcode_q = b[3:0];
               ps       = PS_HEAD1;
            end
         end
         PS_HEAD1: begin
            masked_q = b[7];
            length_q = b[6:0];
            if (opcode_q[3]) begin
               if (length_q > ctl_limit) protocol_error(CAUSE_CTL_LONG);
               else if (!fin_q) protocol_error(CAUSE_CTL_FRAG);
            end else if (opcode_q == OP_BINARY || opcode_q == OP_CONT) begin
               if (int'(length_q) + int'(msg_bytes_q) > int'(msg_limit))
                  protocol_error(CAUSE_MSG_LONG);
               else if (opcode_q == OP_CONT && msg_bytes_q == 7'd0)
                  protocol_error(CAUSE_ORPHAN);
               else if (length_q == 7'd0 && !fin_q)
                  protocol_error(CAUSE_EMPTY_FRAG);
            end else begin
               protocol_error(CAUSE_BAD_DATA);
            end
            if (ps != PS_DEAD) begin
               if (masked_q) begin
                  index_q = 7'd0;
                  key_q   = 32'd0;
                  ps      = PS_KEY;
               end else begin
                  header_complete();
               end
            end
         end
         PS_KEY: begin
            key_q   = {key_q[23:0], b};
            index_q = index_q + 7'd1;
            if (index_q == 7'd4) header_complete();
         end
         PS_PAYLOAD: begin
            // first key byte received unmasks payload bytes 0, 4, 8 ...
            d = b;
            if (masked_q) d = b ^ 8'(key_q >> (24 - 8 * int'(index_q[1:0])));
            at_end  = (int'(index_q) + 1 >= int'(length_q));
            index_q = index_q + 7'd1;
            if (at_end) ps = PS_HEAD0;
            if (!opcode_q[3]) begin
               msg_bytes_q = msg_bytes_q + 7'd1;
               if (at_end && fin_q) msg_bytes_q = 7'd0;
               report(K_MSG, d, at_end & fin_q, 3'd0);
            end else if (opcode_q == OP_PING) begin
               report(K_PING, d, at_end, 3'd0);
            end else if (at_end) begin
               control_complete();
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- generator

   function automatic void stage(logic [7:0] b);
      rx_stream.push_back(b);
      staged_bytes++;
   endfunction

   // Mostly short lengths, now and then anything up to the limit
   function automatic int pick_size(int lim);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, lim);
      return $urandom_range(0, lim < 12 ? lim : 12);
   endfunction

   function automatic void add_frame(logic fin, logic [3:0] op, int len);
      logic masked;
      masked = 1'($urandom);
      stage({fin, 3'b000, op});
      stage({masked, 7'(len)});
      if (masked) repeat (4) stage(8'($urandom));
      repeat (len) stage(8'($urandom));
   endfunction

   function automatic void add_control(logic [3:0] op);
      add_frame(1'b1, op, pick_size(gen_ctl));
   endfunction

   // One data message, possibly fragmented, with pings and pongs in between
   function automatic void add_message();
      int   left;
      int   part;
      logic fin;
      logic first_part;
      left       = pick_size(gen_msg);
      first_part = 1'b1;
      do begin
         part = (left == 0) ? 0 : $urandom_range(1, left);
         fin  = (part == left);
         if (fin && part != 0 && $urandom_range(0, 4) == 0) fin = 1'b0;
         add_frame(fin, first_part ? OP_BINARY : OP_CONT, part);
         first_part = 1'b0;
         left -= part;
         if (!fin && $urandom_range(0, 3) == 0)
            add_control($urandom_range(0, 1) ? OP_PING : OP_PONG);
      end while (!fin);
   endfunction

   function automatic void add_traffic(int target);
      int goal;
      goal = staged_bytes + target;
      while (staged_bytes < goal) begin
         case ($urandom_range(0, 9))
            6, 7:    add_control(OP_PING);
            8, 9:    add_control(OP_PONG);
            default: add_message();
         endcase
      end
   endfunction

   // The stream can end only once: a close or one protocol violation
   function automatic void add_terminal();
      int choice;
      choice = $urandom_range(0, 8);
      case (choice)
         CAUSE_RSV: begin
            stage({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
            closing_note = "reserved bits set";
         end
         CAUSE_CTL_LONG: begin
            add_frame(1'($urandom), 4'($urandom_range(8, 15)),
                      $urandom_range(gen_ctl + 1, 127));
            closing_note = "oversized control frame";
         end
         CAUSE_CTL_FRAG: begin
            add_frame(1'b0, 4'($urandom_range(8, 15)), pick_size(gen_ctl));
            closing_note = "fragmented control frame";
         end
         CAUSE_MSG_LONG: begin
            add_frame(1'($urandom), OP_BINARY, $urandom_range(gen_msg + 1, 127));
            closing_note = "oversized message";
         end
         CAUSE_ORPHAN: begin
            add_frame(1'($urandom), OP_CONT, $urandom_range(0, gen_msg));
            closing_note = "continuation without a message";
         end
         CAUSE_EMPTY_FRAG: begin
            add_frame(1'b0, OP_BINARY, 0);
            closing_note = "empty non-final fragment";
         end
         CAUSE_BAD_DATA: begin
            add_frame(1'($urandom),
                      ($urandom_range(0, 5) == 0) ? 4'h1 : 4'($urandom_range(3, 7)),
                      $urandom_range(0, 127));
            closing_note = "unsupported data opcode";
         end
         CAUSE_BAD_CTL: begin
            add_frame(1'b1, 4'($urandom_range(11, 15)), pick_size(gen_ctl));
            closing_note = "unknown control opcode";
         end
         default: begin
            add_frame(1'b1, OP_CLOSE, pick_size(gen_ctl));
            closing_note = "close frame";
         end
      endcase
      // the block must ignore everything after this
      repeat (16) stage(8'($urandom));
   endfunction

   // ---------------------------------------------------------------- sequencing

   task automatic wait_idle();
      do @(negedge clock);
      while (rx_stream.size() != 0 || push || awaited.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limits(int ctl, int msg);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAX_CTL;
      csr_wdata <= 7'(ctl);
      @(posedge clock);
      csr_index <= CSR_MAX_MSG;
      csr_wdata <= 7'(msg);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gen_ctl = ctl;
      gen_msg = msg;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [7:0] opening [25];
      opening = '{
         8'h82, 8'h00,                                     // empty final message
         8'h89, 8'h00,                                     // empty ping
         8'h8A, 8'h01, 8'hFF,                              // pong, no result
         8'h02, 8'h81, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,  // masked first fragment
         8'h80, 8'h02, 8'hFF, 8'h00,                       // final continuation
         8'h89, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'h5A   // masked ping
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset limits; sender idles lightly, receiver heavily, one long hold
      foreach (opening[i]) stage(opening[i]);
      add_traffic(600);
      hold_wanted = 1'b1;
      wait_idle();

      // Control limit 0 and message limit 1, idling the other way round
      write_limits(0, 1);
      send_idle_pct = 73;
      recv_idle_pct = 17;
      add_traffic(400);
      wait_idle();

      // Limits above the nominal range: lengths 126 and 127 pass, no idling
      write_limits(127, 127);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_frame(1'b1, OP_BINARY, 127);
      add_frame(1'b1, OP_PING, 126);
      add_frame(1'b1, OP_PONG, 127);
      add_traffic(100);
      wait_idle();

      // Random limits, then the stream is closed or broken
      write_limits($urandom_range(0, 125), $urandom_range(0, 126));
      add_traffic(250);
      add_terminal();
      wait_idle();

      $display("Checked %0d results from %0d bytes under four limit settings,",
               results_checked, bytes_taken);
      $display("input stalled %0d cycles; stream ended with %s; %0d mismatches",
               stall_cycles, closing_note, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         push        <= 1'b0;
         req_rx_byte <= 8'h00;
         ps          = PS_HEAD0;
         fin_q       = 1'b0;
         opcode_q    = 4'h0;
         masked_q    = 1'b0;
         length_q    = 7'd0;
         index_q     = 7'd0;
         key_q       = 32'd0;
         msg_bytes_q = 7'd0;
      end else begin
         if (push && !full) begin
            deframe_byte(req_rx_byte);
            void'(rx_stream.pop_front());
            bytes_taken++;
         end
         if (push && full) begin
            // keep offering the same item until there is room
            stall_cycles++;
         end else if (rx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            push        <= 1'b1;
            req_rx_byte <= rx_stream[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Limit registers as the block should hold them
   always @(posedge clock) begin
      if (reset) begin
         ctl_limit <= MAX_CTL_RESET;
         msg_limit <= MAX_MSG_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_MAX_CTL) ctl_limit <= csr_wdata;
         else msg_limit <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : receiver
      deframed_type due;
      if (reset) begin
         pop         <= 1'b0;
         hold_cycles = 0;
         hold_done   = 1'b0;
      end else begin
         if (pop && !empty) begin
            if (awaited.size() == 0) begin
               errors++;
               $display("%0t: expected no result, got kind %0d byte %02h last %0d cause %0d",
                        $time, rsp_kind, rsp_payload_byte, rsp_is_last,
                        rsp_error_cause);
            end else begin
               due = awaited.pop_front();
               results_checked++;
               if (rsp_kind !== due.kind || rsp_payload_byte !== due.data ||
                   rsp_is_last !== due.last || rsp_error_cause !== due.cause) begin
                  errors++;
                  $display("%0t: expected kind %0d byte %02h last %0d cause %0d,",
                           $time, due.kind, due.data, due.last, due.cause);
                  $display("%0t:      got kind %0d byte %02h last %0d cause %0d",
                           $time, rsp_kind, rsp_payload_byte, rsp_is_last,
                           rsp_error_cause);
               end
            end
         end
         // one long hold so that the block fills and pushes back
         if (hold_wanted && !hold_done) begin
            pop <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= HOLD_SPAN) hold_done = 1'b1;
         end else begin
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

`default_nettype wire
